// ----- rtl/dcot_pkg.sv -----
// Shared constants, codes and types of the data channel open table.
`default_nettype none

package dcot_pkg;

    // Table size (2 to 256 entries) and the index width it implies
    localparam int CHANNELS = 128;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Lowest-free search: entries are scanned in groups of GRP_SIZE
    localparam int GRP_SIZE = 16;
    localparam int GRP_W    = $clog2(GRP_SIZE);
    localparam int GROUPS   = (CHANNELS + GRP_SIZE - 1) / GRP_SIZE;

    // Request kinds
    localparam logic [1:0] KIND_LOCAL_OPEN = 2'd0;
    localparam logic [1:0] KIND_RX_OPEN    = 2'd1;
    localparam logic [1:0] KIND_RX_RESP    = 2'd2;
    localparam logic [1:0] KIND_OTHER      = 2'd3;

    // Result status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_RANGE      = 4'd1;
    localparam logic [3:0] ST_BUSY       = 4'd3;
    localparam logic [3:0] ST_ALREADY    = 4'd4;
    localparam logic [3:0] ST_NONE_FREE  = 4'd5;
    localparam logic [3:0] ST_NOT_PEND   = 4'd6;
    localparam logic [3:0] ST_PEER_ERR   = 4'd7;
    localparam logic [3:0] ST_UNKNOWN    = 4'd8;

    // Channel types
    localparam logic [1:0] CT_RELIABLE   = 2'd0;
    localparam logic [1:0] CT_PR_TIMED   = 2'd3;

    // Send modes
    localparam logic [1:0] MODE_RELIABLE = 2'd0;
    localparam logic [1:0] MODE_REXMIT   = 2'd1;
    localparam logic [1:0] MODE_TIMED    = 2'd2;

    // Response error codes
    localparam logic [1:0] SERR_NONE       = 2'd0;
    localparam logic [1:0] SERR_ALREADY    = 2'd1;
    localparam logic [1:0] SERR_NONE_AVAIL = 2'd2;

    localparam logic [15:0] NO_STREAM = 16'hFFFF;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  stream;
        logic [1:0]  chan_type;
        logic [15:0] chan_flags;
        logic [15:0] reliability;
        logic [15:0] peer_reverse;
        logic [15:0] peer_error;
    } req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        send_valid;
        logic        send_is_response;
        logic [7:0]  send_stream;
        logic [15:0] send_reverse;
        logic [1:0]  send_error;
        logic [1:0]  send_mode;
        logic [7:0]  open_count;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic search;
        logic commit;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/dcot_if.sv -----
// Request and result channel interfaces of the data channel open table.
`default_nettype none

interface dcot_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  stream;
    logic [1:0]  chan_type;
    logic [15:0] chan_flags;
    logic [15:0] reliability;
    logic [15:0] peer_reverse;
    logic [15:0] peer_error;

    modport source (
        output valid, kind, stream, chan_type, chan_flags, reliability,
               peer_reverse, peer_error,
        input  ready
    );
    modport sink (
        input  valid, kind, stream, chan_type, chan_flags, reliability,
               peer_reverse, peer_error,
        output ready
    );
endinterface

interface dcot_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic        send_valid;
    logic        send_is_response;
    logic [7:0]  send_stream;
    logic [15:0] send_reverse;
    logic [1:0]  send_error;
    logic [1:0]  send_mode;
    logic [7:0]  open_count;

    modport source (
        output valid, status, send_valid, send_is_response, send_stream,
               send_reverse, send_error, send_mode, open_count,
        input  ready
    );
    modport sink (
        input  valid, status, send_valid, send_is_response, send_stream,
               send_reverse, send_error, send_mode, open_count,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/dcot_ctrl.sv -----
// Controller state machine: request intake, search, commit and result valid.
`default_nettype none

module dcot_ctrl
    import dcot_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output cmd_t      cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;

    // Commands
    assign req_ready  = (state_reg == S_IDLE);
    assign cmd.load   = req_valid && req_ready;
    assign cmd.search = (state_reg == S_SEARCH);
    // commit only when the result register is empty or being drained
    assign cmd.commit = (state_reg == S_DECIDE) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid  = rsp_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                    state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (cmd.commit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dcot_dp.sv -----
// Datapath: per-stream tables, lowest-free search, decision and result register.
`default_nettype none

module dcot_dp
    import dcot_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    input  wire req_t req_data,
    output rsp_t      rsp_data
);

    // Captured request
    logic [1:0]       kind_reg;
    logic [7:0]       stream_reg;
    logic [1:0]       ctype_reg;
    logic             stream_ok_reg;
    logic             prev_ok_reg;
    logic [IDX_W-1:0] prev_idx_reg;
    logic             perr_nz_reg;

    // Per-stream tables and open counter
    logic [CHANNELS-1:0] pend_reg, pend_next;
    logic [CHANNELS-1:0] link_reg, link_next;
    logic [CHANNELS-1:0] busy_reg, busy_next;
    logic [7:0]          count_reg, count_next;

    // Search: lowest free entry inside each group, then lowest group
    logic [CHANNELS-1:0]              free_vec;
    logic [GROUPS*GRP_SIZE-1:0]       free_pad;
    logic [GROUPS-1:0]                grp_any_reg, grp_any_next;
    logic [GROUPS-1:0][GRP_W-1:0]     grp_low_reg, grp_low_next;
    logic [IDX_W-1:0]                 low_idx;
    logic                             any_free;

    logic [IDX_W-1:0] s_idx;
    logic [IDX_W-1:0] fwd_idx;
    logic             inc;
    rsp_t             rsp_reg, rsp_next;

    assign s_idx    = stream_reg[IDX_W-1:0];
    assign free_vec = ~(pend_reg | link_reg);
    assign any_free = |grp_any_reg;
    assign rsp_data = rsp_reg;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg      <= req_data.kind;
            stream_reg    <= req_data.stream;
            ctype_reg     <= req_data.chan_type;
            stream_ok_reg <= ({1'b0, req_data.stream} < 9'(CHANNELS));
            prev_ok_reg   <= ({1'b0, req_data.peer_reverse} < 17'(CHANNELS));
            prev_idx_reg  <= req_data.peer_reverse[IDX_W-1:0];
            perr_nz_reg   <= (req_data.peer_error != 16'd0);
        end
    end

    // Free flags padded to whole groups; padding is never free
    always_comb
    begin
        free_pad                 = '0;
        free_pad[CHANNELS-1:0]   = free_vec;
    end

    // Priority encoder per group
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_low_next[g] = '0;
            for (int w = GRP_SIZE - 1; w >= 0; w--)
            begin
                if (free_pad[g*GRP_SIZE + w])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_low_next[g] = GRP_W'(w);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            grp_any_reg <= grp_any_next;
            grp_low_reg <= grp_low_next;
        end
    end

    // Lowest group holding a free entry
    always_comb
    begin
        low_idx = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
                low_idx = IDX_W'(g * GRP_SIZE + int'(grp_low_reg[g]));
        end
    end

    // Decision and table updates
    always_comb
    begin
        pend_next = pend_reg;
        link_next = link_reg;
        busy_next = busy_reg;
        inc       = 1'b0;
        fwd_idx   = free_vec[s_idx] ? s_idx : low_idx;

        rsp_next                  = '0;
        rsp_next.status           = ST_OK;
        rsp_next.send_reverse     = NO_STREAM;
        rsp_next.send_error       = SERR_NONE;
        rsp_next.send_mode        = MODE_RELIABLE;

        if (kind_reg == KIND_OTHER)
        begin
            rsp_next.status = ST_UNKNOWN;
        end
        else if (!stream_ok_reg || (kind_reg == KIND_RX_RESP && !prev_ok_reg))
        begin
            rsp_next.status = ST_RANGE;
        end
        else if (kind_reg == KIND_LOCAL_OPEN)
        begin
            if (!free_vec[s_idx])
            begin
                rsp_next.status = ST_BUSY;
            end
            else
            begin
                pend_next[s_idx]     = 1'b1;
                rsp_next.send_valid  = 1'b1;
                rsp_next.send_stream = stream_reg;
                case (ctype_reg)
                    CT_RELIABLE: rsp_next.send_mode = MODE_RELIABLE;
                    CT_PR_TIMED: rsp_next.send_mode = MODE_TIMED;
                    default:     rsp_next.send_mode = MODE_REXMIT;
                endcase
            end
        end
        else if (kind_reg == KIND_RX_OPEN)
        begin
            rsp_next.send_valid       = 1'b1;
            rsp_next.send_is_response = 1'b1;
            rsp_next.send_reverse     = {8'd0, stream_reg};
            if (busy_reg[s_idx])
            begin
                rsp_next.status      = ST_ALREADY;
                rsp_next.send_stream = stream_reg;
                rsp_next.send_error  = SERR_ALREADY;
            end
            else if (!free_vec[s_idx] && !any_free)
            begin
                rsp_next.status      = ST_NONE_FREE;
                rsp_next.send_stream = stream_reg;
                rsp_next.send_error  = SERR_NONE_AVAIL;
            end
            else
            begin
                link_next[fwd_idx]   = 1'b1;
                busy_next[s_idx]     = 1'b1;
                rsp_next.send_stream = 8'(fwd_idx);
                inc                  = 1'b1;
            end
        end
        else
        begin
            // received open response
            if (!pend_reg[prev_idx_reg])
            begin
                rsp_next.status = ST_NOT_PEND;
            end
            else if (perr_nz_reg)
            begin
                rsp_next.status = ST_PEER_ERR;
            end
            else
            begin
                pend_next[prev_idx_reg] = 1'b0;
                link_next[prev_idx_reg] = 1'b1;
                busy_next[s_idx]        = 1'b1;
                inc                     = 1'b1;
            end
        end

        // saturating open count
        count_next = count_reg;
        if (inc && count_reg != COUNT_MAX)
            count_next = count_reg + 8'd1;
        rsp_next.open_count = count_next;
    end

    // Tables and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            link_reg  <= '0;
            busy_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            pend_reg  <= pend_next;
            link_reg  <= link_next;
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

// ----- rtl/data_channel_open_table_top.sv -----
// Top level of the data channel open table.
`default_nettype none

// Data channel open table. Keeps, for each of CHANNELS streams, an outgoing
// pending mark, an outgoing linked mark and an incoming in-use mark, plus a
// count of opened channels that saturates at 255. Each request on req gives
// exactly one result on rsp. After acceptance a request is captured, then the
// lowest free outgoing entry is found inside each group of GRP_SIZE entries
// with a small priority encoder per group, then the lowest group holding a
// free entry is picked, the request decided and the tables updated. The
// block holds one request at a time and takes no new request until the
// current one is decided; the result register lets the next request be
// taken while an earlier result waits, and the decide step waits until that
// register is free. No clearing pass is needed after reset.
module data_channel_open_table_top
    import dcot_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dcot_req_if.sink    req,
    dcot_rsp_if.source  rsp
);

    cmd_t cmd;
    req_t req_data;
    rsp_t rsp_data;

    // Request payload
    assign req_data.kind         = req.kind;
    assign req_data.stream       = req.stream;
    assign req_data.chan_type    = req.chan_type;
    assign req_data.chan_flags   = req.chan_flags;
    assign req_data.reliability  = req.reliability;
    assign req_data.peer_reverse = req.peer_reverse;
    assign req_data.peer_error   = req.peer_error;

    dcot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    dcot_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

    // Result payload
    assign rsp.status           = rsp_data.status;
    assign rsp.send_valid       = rsp_data.send_valid;
    assign rsp.send_is_response = rsp_data.send_is_response;
    assign rsp.send_stream      = rsp_data.send_stream;
    assign rsp.send_reverse     = rsp_data.send_reverse;
    assign rsp.send_error       = rsp_data.send_error;
    assign rsp.send_mode        = rsp_data.send_mode;
    assign rsp.open_count       = rsp_data.open_count;

    // A commit always leaves a result waiting
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("commit did not produce a valid result");

    // Only one request in flight
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in flight");

    // Open count never goes backwards
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && $past(rsp.valid)) |-> rsp.open_count >= $past(rsp.open_count))
        else $error("open count decreased");

    // Error codes only travel in responses
    a_err_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.send_error != SERR_NONE) |-> (rsp.send_is_response && rsp.send_valid))
        else $error("error code outside an open response");

endmodule

`default_nettype wire
